// File: design/ascii_sensor_frame_parser_macros.svh
// Assertion macros for the sensor frame parser.
`ifndef ASCII_SENSOR_FRAME_PARSER_MACROS_SVH
`define ASCII_SENSOR_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASFP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define ASFP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/asfp_pkg.sv
// Types and character codes for the sensor frame parser.
`timescale 1ns / 1ps

package asfp_pkg;

    localparam logic [7:0] CH_START  = 8'h24;  // '$'
    localparam logic [7:0] CH_END    = 8'h23;  // '#'
    localparam logic [7:0] CH_HEADER = 8'h41;  // 'A'
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [3:0]  FIELD_CAP = 4'd9;
    localparam logic [1:0]  SUB_CAP   = 2'd2;
    localparam logic [16:0] MAG_CAP   = 17'd32768;
    localparam logic [15:0] POS_MAX   = 16'd32767;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HEADER = 2'd1,
        ST_TOO_LONG   = 2'd2
    } frame_status_t;

    typedef enum logic [1:0] {
        NUM_BLANKS  = 2'd0,
        NUM_DIGITS  = 2'd1,
        NUM_STOPPED = 2'd2
    } num_phase_t;

endpackage

// File: design/ascii_sensor_frame_parser.sv
// Byte-at-a-time parser for "$A,IR1:v1,...#" sensor frames.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------------
//  s_      | in  | s_valid / s_ready  | s_rx_byte
//  m_      | out | m_valid / m_ready  | m_frame_status, m_value_0..7, m_updated_mask
//
// One byte is taken per cycle; a status result appears the cycle after its '#'
// (or aborting byte) is taken. The output stage is a single register: a byte is
// refused only while a result waits and m_ready is low.
// aresetn is synchronous, active low; it clears parser state and sensor values.
// m_value_* come straight from the sensor value registers, which only change on
// a committing '#', and that cannot be taken while an older result still waits.
`timescale 1ns / 1ps

module ascii_sensor_frame_parser
    import asfp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 128,
    parameter int SENSOR_COUNT    = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_frame_status,
    output logic signed [15:0] m_value_0,
    output logic signed [15:0] m_value_1,
    output logic signed [15:0] m_value_2,
    output logic signed [15:0] m_value_3,
    output logic signed [15:0] m_value_4,
    output logic signed [15:0] m_value_5,
    output logic signed [15:0] m_value_6,
    output logic signed [15:0] m_value_7,
    output logic [7:0]  m_updated_mask
);

`include "ascii_sensor_frame_parser_macros.svh"

    localparam logic [7:0] MAX_B = 8'(MAX_FRAME_BYTES);

    // parser state
    logic        in_frame_reg, in_frame_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic        header_a_reg, header_a_next;
    logic        text_ended_reg, text_ended_next;
    logic [3:0]  field_index_reg, field_index_next;
    logic        field_nonempty_reg, field_nonempty_next;
    logic [1:0]  sub_index_reg, sub_index_next;
    logic        sub_nonempty_reg, sub_nonempty_next;
    num_phase_t  phase_reg, phase_next;
    logic        negative_reg, negative_next;
    logic [16:0] acc_reg, acc_next;
    logic [15:0] pending_reg [SENSOR_COUNT];
    logic [15:0] pending_next [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] pending_mask_reg, pending_mask_next;
    logic [15:0] sensor_reg [SENSOR_COUNT];
    logic [15:0] sensor_next [SENSOR_COUNT];

    // result stage
    logic          m_valid_reg, m_valid_next;
    frame_status_t status_reg, status_next;
    logic [SENSOR_COUNT-1:0] mask_reg, mask_next;

    logic        accept;
    logic        emit;
    logic        is_digit;
    logic        is_blank;
    logic [19:0] acc_times10;
    logic [15:0] num_value;

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_digit = (s_rx_byte >= CH_ZERO) && (s_rx_byte <= CH_NINE);
    assign is_blank = (s_rx_byte == CH_SPACE) ||
                      ((s_rx_byte >= CH_TAB) && (s_rx_byte <= CH_CR));
    assign acc_times10 = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0}
                       + {16'd0, s_rx_byte[3:0]};

    // value of the number after this byte is fed in
    always_comb begin
        if (negative_next) begin
            num_value = 16'(17'd0 - acc_next);
        end else if (acc_next > {1'b0, POS_MAX}) begin
            num_value = POS_MAX;
        end else begin
            num_value = acc_next[15:0];
        end
    end

    always_comb begin
        logic feed;
        in_frame_next       = in_frame_reg;
        byte_count_next     = byte_count_reg;
        header_a_next       = header_a_reg;
        text_ended_next     = text_ended_reg;
        field_index_next    = field_index_reg;
        field_nonempty_next = field_nonempty_reg;
        sub_index_next      = sub_index_reg;
        sub_nonempty_next   = sub_nonempty_reg;
        phase_next          = phase_reg;
        negative_next       = negative_reg;
        acc_next            = acc_reg;
        pending_next        = pending_reg;
        pending_mask_next   = pending_mask_reg;
        sensor_next         = sensor_reg;
        emit                = 1'b0;
        status_next         = status_reg;
        mask_next           = mask_reg;
        feed                = 1'b0;

        if (accept) begin
            if (s_rx_byte == CH_START) begin
                in_frame_next       = 1'b1;
                byte_count_next     = 8'd1;
                header_a_next       = 1'b0;
                text_ended_next     = 1'b0;
                field_index_next    = 4'd0;
                field_nonempty_next = 1'b1;
                sub_index_next      = 2'd0;
                sub_nonempty_next   = 1'b1;
                phase_next          = NUM_BLANKS;
                negative_next       = 1'b0;
                acc_next            = 17'd0;
                pending_mask_next   = '0;
            end else if (in_frame_reg) begin
                if (byte_count_reg >= MAX_B) begin
                    in_frame_next   = 1'b0;
                    byte_count_next = 8'd0;
                    emit            = 1'b1;
                    status_next     = ST_TOO_LONG;
                    mask_next       = '0;
                end else begin
                    if (byte_count_reg == 8'd1) begin
                        header_a_next = (s_rx_byte == CH_HEADER);
                    end
                    byte_count_next = byte_count_reg + 8'd1;
                    if (s_rx_byte == CH_END) begin
                        in_frame_next   = 1'b0;
                        byte_count_next = 8'd0;
                        emit            = 1'b1;
                        if (header_a_next) begin
                            status_next = ST_OK;
                            mask_next   = pending_mask_reg;
                            for (int k = 0; k < SENSOR_COUNT; k++) begin
                                if (pending_mask_reg[k]) begin
                                    sensor_next[k] = pending_reg[k];
                                end
                            end
                        end else begin
                            status_next = ST_BAD_HEADER;
                            mask_next   = '0;
                        end
                    end else if (text_ended_reg) begin
                        // text is over; bytes only count toward the length
                    end else if (s_rx_byte == CH_NUL) begin
                        text_ended_next = 1'b1;
                    end else if (s_rx_byte == CH_COMMA) begin
                        if (field_nonempty_reg && (field_index_reg < FIELD_CAP)) begin
                            field_index_next = field_index_reg + 4'd1;
                        end
                        field_nonempty_next = 1'b0;
                        sub_index_next      = 2'd0;
                        sub_nonempty_next   = 1'b0;
                        phase_next          = NUM_BLANKS;
                        negative_next       = 1'b0;
                        acc_next            = 17'd0;
                    end else if (s_rx_byte == CH_COLON) begin
                        field_nonempty_next = 1'b1;
                        if (sub_nonempty_reg && (sub_index_reg < SUB_CAP)) begin
                            sub_index_next = sub_index_reg + 2'd1;
                        end
                        sub_nonempty_next = 1'b0;
                        phase_next        = NUM_BLANKS;
                        negative_next     = 1'b0;
                        acc_next          = 17'd0;
                    end else begin
                        field_nonempty_next = 1'b1;
                        sub_nonempty_next   = 1'b1;
                        feed = (sub_index_reg == 2'd1) && (field_index_reg != 4'd0) &&
                               ({28'd0, field_index_reg} <= SENSOR_COUNT);
                    end
                end
            end
        end

        // atoi step on the second sub-token
        if (feed) begin
            case (phase_reg)
                NUM_BLANKS: begin
                    if (is_blank) begin
                        phase_next = NUM_BLANKS;
                    end else if ((s_rx_byte == CH_PLUS) || (s_rx_byte == CH_MINUS)) begin
                        negative_next = (s_rx_byte == CH_MINUS);
                        phase_next    = NUM_DIGITS;
                    end else if (is_digit) begin
                        acc_next   = {13'd0, s_rx_byte[3:0]};
                        phase_next = NUM_DIGITS;
                    end else begin
                        phase_next = NUM_STOPPED;
                    end
                end
                NUM_DIGITS: begin
                    if (is_digit) begin
                        acc_next = (acc_times10 > {3'd0, MAG_CAP}) ? MAG_CAP
                                                                    : acc_times10[16:0];
                    end else begin
                        phase_next = NUM_STOPPED;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
            for (int k = 0; k < SENSOR_COUNT; k++) begin
                if (field_index_reg == 4'(k + 1)) begin
                    pending_next[k]      = num_value;
                    pending_mask_next[k] = 1'b1;
                end
            end
        end

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg       <= 1'b0;
            byte_count_reg     <= 8'd0;
            header_a_reg       <= 1'b0;
            text_ended_reg     <= 1'b0;
            field_index_reg    <= 4'd0;
            field_nonempty_reg <= 1'b0;
            sub_index_reg      <= 2'd0;
            sub_nonempty_reg   <= 1'b0;
            phase_reg          <= NUM_BLANKS;
            negative_reg       <= 1'b0;
            acc_reg            <= 17'd0;
            pending_mask_reg   <= '0;
            m_valid_reg        <= 1'b0;
            for (int k = 0; k < SENSOR_COUNT; k++) begin
                sensor_reg[k] <= 16'd0;
            end
        end else begin
            in_frame_reg       <= in_frame_next;
            byte_count_reg     <= byte_count_next;
            header_a_reg       <= header_a_next;
            text_ended_reg     <= text_ended_next;
            field_index_reg    <= field_index_next;
            field_nonempty_reg <= field_nonempty_next;
            sub_index_reg      <= sub_index_next;
            sub_nonempty_reg   <= sub_nonempty_next;
            phase_reg          <= phase_next;
            negative_reg       <= negative_next;
            acc_reg            <= acc_next;
            pending_mask_reg   <= pending_mask_next;
            m_valid_reg        <= m_valid_next;
            sensor_reg         <= sensor_next;
        end
    end

    // payload only: pending entries are gated by the mask, results by m_valid
    always_ff @(posedge aclk) begin
        pending_reg <= pending_next;
        status_reg  <= status_next;
        mask_reg    <= mask_next;
    end

    logic [15:0] value_out [8];

    for (genvar g = 0; g < 8; g++) begin : g_value
        if (g < SENSOR_COUNT) begin : g_used
            assign value_out[g] = sensor_reg[g];
        end else begin : g_unused
            assign value_out[g] = 16'd0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_frame_status = status_reg;
    assign m_updated_mask = 8'(mask_reg);
    assign m_value_0      = value_out[0];
    assign m_value_1      = value_out[1];
    assign m_value_2      = value_out[2];
    assign m_value_3      = value_out[3];
    assign m_value_4      = value_out[4];
    assign m_value_5      = value_out[5];
    assign m_value_6      = value_out[6];
    assign m_value_7      = value_out[7];

    `ASFP_ASSERT_NOW(a_mask_only_ok, aclk, aresetn, m_valid && (m_updated_mask != 8'd0), m_frame_status == ST_OK, "update mask set on a failed frame")
    `ASFP_ASSERT_NOW(a_idle_count, aclk, aresetn, !in_frame_reg, byte_count_reg == 8'd0, "byte count live outside a frame")
    `ASFP_ASSERT_NOW(a_count_cap, aclk, aresetn, in_frame_reg, (byte_count_reg != 8'd0) && (byte_count_reg <= MAX_B), "frame byte count out of range")
    `ASFP_ASSERT_NEXT(a_start, aclk, aresetn, accept && (s_rx_byte == CH_START), in_frame_reg && (byte_count_reg == 8'd1) && (pending_mask_reg == '0), "start byte did not open a frame")

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the ASCII sensor frame parser: directed and random byte streams.
`timescale 1ns / 1ps

module testbench;
    import asfp_pkg::*;

    localparam int FRAME_MAX    = 128;
    localparam int SENSORS      = 8;
    localparam int RANDOM_BYTES = 500;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_PRINTED  = 30;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    typedef enum int {RDY_ALWAYS, RDY_PATTERN, RDY_RANDOM} ready_mode_t;

    typedef struct {
        frame_status_t            status;
        logic [SENSORS-1:0][15:0] vals;
        logic [7:0]               mask;
    } frame_report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_frame_status;
    logic signed [15:0] m_value_0, m_value_1, m_value_2, m_value_3;
    logic signed [15:0] m_value_4, m_value_5, m_value_6, m_value_7;
    logic [7:0] m_updated_mask;
    logic [SENSORS-1:0][15:0] got_vals;

    assign got_vals = {m_value_7, m_value_6, m_value_5, m_value_4,
                       m_value_3, m_value_2, m_value_1, m_value_0};

    ascii_sensor_frame_parser #(
        .MAX_FRAME_BYTES(FRAME_MAX),
        .SENSOR_COUNT   (SENSORS)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_frame_status(m_frame_status),
        .m_value_0     (m_value_0),
        .m_value_1     (m_value_1),
        .m_value_2     (m_value_2),
        .m_value_3     (m_value_3),
        .m_value_4     (m_value_4),
        .m_value_5     (m_value_5),
        .m_value_6     (m_value_6),
        .m_value_7     (m_value_7),
        .m_updated_mask(m_updated_mask)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow copy of the parser state
    logic                     pp_in_frame = 1'b0;
    logic [7:0]               pp_byte_cnt = 8'd0;
    logic                     pp_header_a = 1'b0;
    logic                     pp_text_ended = 1'b0;
    logic [3:0]               pp_field_idx = 4'd0;
    logic                     pp_field_ne = 1'b0;
    logic [1:0]               pp_sub_idx = 2'd0;
    logic                     pp_sub_ne = 1'b0;
    num_phase_t               pp_num_phase = NUM_BLANKS;
    logic                     pp_num_neg = 1'b0;
    int                       pp_num_mag = 0;
    logic [SENSORS-1:0][15:0] pp_pending_vals = '0;
    logic [7:0]               pp_pending_mask = 8'h00;
    logic [SENSORS-1:0][15:0] pp_sensor_vals = '0;

    frame_report_t frame_reports_due[$];
    logic [7:0]    tx_q[$];

    int frame_bytes = 0;
    int reports_ok = 0;
    int reports_bad_header = 0;
    int reports_too_long = 0;
    int reports_checked = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    bit          sender_bursty = 1'b0;
    int          burst_left = 0;
    ready_mode_t ready_mode = RDY_ALWAYS;
    int          ready_tick = 0;
    int          stall_left = 0;

    task automatic clear_number();
        pp_num_phase = NUM_BLANKS;
        pp_num_neg = 1'b0;
        pp_num_mag = 0;
    endtask

    task automatic push_report(input frame_status_t st, input logic [7:0] mask);
        frame_report_t r;
        r.status = st;
        r.vals = pp_sensor_vals;
        r.mask = mask;
        frame_reports_due.push_back(r);
        case (st)
            ST_OK:         reports_ok++;
            ST_BAD_HEADER: reports_bad_header++;
            default:       reports_too_long++;
        endcase
    endtask

    task automatic predict_parser_byte(input logic [7:0] c);
        int   digit_val;
        int   slot;
        int   k;
        logic is_digit;
        logic is_blank;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        digit_val = int'(c) - int'(CH_ZERO);
        if (c == CH_START) begin
            frame_bytes++;
            pp_in_frame = 1'b1;
            pp_byte_cnt = 8'd1;
            pp_header_a = 1'b0;
            pp_text_ended = 1'b0;
            pp_field_idx = 4'd0;
            pp_field_ne = 1'b1;
            pp_sub_idx = 2'd0;
            pp_sub_ne = 1'b1;
            clear_number();
            pp_pending_vals = '0;
            pp_pending_mask = 8'h00;
            return;
        end
        if (!pp_in_frame) return;
        frame_bytes++;
        if (int'(pp_byte_cnt) >= FRAME_MAX) begin
            pp_in_frame = 1'b0;
            pp_byte_cnt = 8'd0;
            push_report(ST_TOO_LONG, 8'h00);
            return;
        end
        if (pp_byte_cnt == 8'd1) pp_header_a = (c == CH_HEADER);
        pp_byte_cnt++;
        if (c == CH_END) begin
            pp_in_frame = 1'b0;
            pp_byte_cnt = 8'd0;
            if (pp_header_a) begin
                for (k = 0; k < SENSORS; k++)
                    if (pp_pending_mask[k]) pp_sensor_vals[k] = pp_pending_vals[k];
                push_report(ST_OK, pp_pending_mask);
            end else begin
                push_report(ST_BAD_HEADER, 8'h00);
            end
            return;
        end
        if (pp_text_ended) return;
        if (c == CH_NUL) begin
            pp_text_ended = 1'b1;
            return;
        end
        if (c == CH_COMMA) begin
            if (pp_field_ne && pp_field_idx < FIELD_CAP) pp_field_idx++;
            pp_field_ne = 1'b0;
            pp_sub_idx = 2'd0;
            pp_sub_ne = 1'b0;
            clear_number();
            return;
        end
        pp_field_ne = 1'b1;
        if (c == CH_COLON) begin
            if (pp_sub_ne && pp_sub_idx < SUB_CAP) pp_sub_idx++;
            pp_sub_ne = 1'b0;
            clear_number();
            return;
        end
        pp_sub_ne = 1'b1;
        // only the second sub-token of sensor tokens carries a value
        if (pp_sub_idx != 2'd1 || pp_field_idx == 4'd0 || int'(pp_field_idx) > SENSORS) return;
        slot = int'(pp_field_idx) - 1;
        case (pp_num_phase)
            NUM_BLANKS: begin
                if (!is_blank) begin
                    if (c == CH_PLUS || c == CH_MINUS) begin
                        pp_num_neg = (c == CH_MINUS);
                        pp_num_phase = NUM_DIGITS;
                    end else if (is_digit) begin
                        pp_num_mag = digit_val;
                        pp_num_phase = NUM_DIGITS;
                    end else begin
                        pp_num_phase = NUM_STOPPED;
                    end
                end
            end
            NUM_DIGITS: begin
                if (is_digit) begin
                    pp_num_mag = pp_num_mag * 10 + digit_val;
                    if (pp_num_mag > int'(MAG_CAP)) pp_num_mag = int'(MAG_CAP);
                end else begin
                    pp_num_phase = NUM_STOPPED;
                end
            end
            default: ;
        endcase
        if (pp_num_neg) pp_pending_vals[slot] = 16'(65536 - pp_num_mag);
        else if (pp_num_mag > int'(POS_MAX)) pp_pending_vals[slot] = POS_MAX;
        else pp_pending_vals[slot] = 16'(pp_num_mag);
        pp_pending_mask[slot] = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want_v);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch in %s at report %0d: got %0d, want %0d",
                     what, reports_checked, got, want_v);
    endtask

    // Result checker
    always @(posedge aclk) begin : check_reports
        frame_report_t want;
        int k;
        if (aresetn && m_valid && m_ready) begin
            if (frame_reports_due.size() == 0) begin
                report_mismatch("unexpected frame report", int'(m_frame_status), -1);
            end else begin
                want = frame_reports_due.pop_front();
                reports_checked++;
                if (m_frame_status !== want.status)
                    report_mismatch("frame_status", int'(m_frame_status), int'(want.status));
                for (k = 0; k < SENSORS; k++)
                    if (got_vals[k] !== want.vals[k])
                        report_mismatch($sformatf("value_%0d", k),
                                        int'($signed(got_vals[k])), int'($signed(want.vals[k])));
                if (m_updated_mask !== want.mask)
                    report_mismatch("updated_mask", int'(m_updated_mask), int'(want.mask));
            end
        end
    end

    // Receiver stall pattern
    always @(posedge aclk) begin
        ready_tick++;
        case (ready_mode)
            RDY_ALWAYS:  m_ready <= 1'b1;
            RDY_PATTERN: m_ready <= (ready_tick % 7) < 4;
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 15);
                end
            end
        endcase
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports still due",
                     cycle_count, frame_reports_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_rx_byte(input logic [7:0] b);
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        predict_parser_byte(b);
        if (burst_left > 0) begin
            burst_left--;
        end else if (sender_bursty) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(0, 24);
        end
    endtask

    task automatic send_queued();
        while (tx_q.size() != 0) send_rx_byte(tx_q.pop_front());
    endtask

    task automatic put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) tx_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] rand_text_byte(input bit allow_end);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CH_START || (!allow_end && b == CH_END));
        return b;
    endfunction

    task automatic put_number_text();
        int pick;
        int n_digits;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            repeat ($urandom_range(1, 3))
                tx_q.push_back(($urandom_range(0, 2) == 0) ? CH_SPACE
                                                            : 8'($urandom_range(CH_TAB, CH_CR)));
        pick = $urandom_range(0, 99);
        if (pick < 25) tx_q.push_back(CH_MINUS);
        else if (pick < 35) tx_q.push_back(CH_PLUS);
        pick = $urandom_range(0, 99);
        n_digits = (pick < 5) ? 0 : (pick < 80) ? $urandom_range(1, 4) : $urandom_range(5, 7);
        repeat (n_digits) tx_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 9) == 0) tx_q.push_back(rand_text_byte(1'b0));
    endtask

    task automatic put_random_frame();
        int         kind;
        int         pick;
        int         t;
        int         n_tokens;
        int         frame_start;
        int         target_len;
        logic [7:0] b;
        frame_start = tx_q.size();
        kind = $urandom_range(0, 99);
        tx_q.push_back(CH_START);
        if (kind < 6) begin
            do b = rand_text_byte(1'b1); while (b == CH_HEADER);
            tx_q.push_back(b);
        end else begin
            tx_q.push_back(CH_HEADER);
        end
        n_tokens = $urandom_range(0, 11);
        for (t = 0; t < n_tokens; t++) begin
            tx_q.push_back(CH_COMMA);
            pick = $urandom_range(0, 99);
            if (pick < 8) continue;
            if (pick < 14) begin
                repeat ($urandom_range(1, 6)) tx_q.push_back(rand_text_byte(1'b0));
                continue;
            end
            put_text("IR");
            tx_q.push_back(8'(CH_ZERO + $urandom_range(1, 8)));
            if (pick < 20) tx_q.push_back(CH_COLON);  // empty sub-token
            tx_q.push_back(CH_COLON);
            put_number_text();
            if (pick >= 90) begin
                tx_q.push_back(CH_COLON);
                put_number_text();
            end
        end
        if (kind >= 6 && kind < 10) begin
            tx_q.push_back(CH_NUL);
            put_text(",IR2:77");
        end
        if (kind >= 10 && kind < 13) begin
            target_len = $urandom_range(FRAME_MAX - 2, FRAME_MAX + 6);
            while (tx_q.size() - frame_start < target_len) tx_q.push_back(rand_text_byte(1'b0));
        end
        // a few frames are abandoned and cut off by the next start
        if (kind < 13 || kind >= 16) tx_q.push_back(CH_END);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) tx_q.push_back(rand_text_byte(1'b1));
    endtask

    task automatic put_long_frame(input int len_before_last, input logic [7:0] last_b);
        int frame_start;
        frame_start = tx_q.size();
        tx_q.push_back(CH_START);
        put_text("A,IR1:42,");
        while (tx_q.size() - frame_start < len_before_last) tx_q.push_back(CH_SPACE);
        tx_q.push_back(last_b);
    endtask

    task automatic test_ignored_bytes();
        sender_bursty = 1'b0;
        ready_mode = RDY_ALWAYS;
        tx_q.push_back(CH_END);
        tx_q.push_back(CH_HEADER);
        tx_q.push_back(CH_NUL);
        tx_q.push_back(8'hFF);
        put_text("IR1:5,#");
        send_queued();
    endtask

    task automatic test_basic_frames();
        put_text("$A,IR1:12,IR2:-34,IR3:+56#");
        put_text("$A#");
        put_text("$A,IR1:7#");
        put_text("$A,a:1,b:2,c:3,d:4,e:5,f:6,g:7,h:8#");
        send_queued();
    endtask

    task automatic test_value_extremes();
        ready_mode = RDY_PATTERN;
        put_text("$A,a:32767,b:32768,c:-32768,d:-32769,e:999999,f:-0,g:000123,h:-999999#");
        send_queued();
    endtask

    task automatic test_value_forms();
        sender_bursty = 1'b1;
        put_text("$A,a:");
        tx_q.push_back(CH_SPACE);
        tx_q.push_back(CH_TAB);
        tx_q.push_back(CH_LF);
        tx_q.push_back(CH_VT);
        tx_q.push_back(CH_FF);
        tx_q.push_back(CH_CR);
        put_text("-7,b:abc,c:+,d:-,e:12x34,f:- 5,g:+-3,h:#");
        send_queued();
    endtask

    task automatic test_token_rules();
        ready_mode = RDY_RANDOM;
        put_text("$A,,,IR1:11,,IR2::22,IR3:33:44,IR4,:7:8#");
        put_text("$A,1:1,2:2,3:3,4:4,5:5,6:6,7:7,8:8,9:9,10:10#");
        put_text("$A:x:1,IR1:5#");
        send_queued();
    endtask

    task automatic test_headers();
        put_text("$B,IR1:5#");
        put_text("$#");
        put_text("$a,IR1:9#");
        put_text("$A,IR1:3$A,IR2:4#");
        put_text("$$A,IR1:-1#");
        send_queued();
    endtask

    task automatic test_zero_byte();
        sender_bursty = 1'b0;
        put_text("$A,IR1:12");
        tx_q.push_back(CH_NUL);
        put_text("34,IR2:9#");
        tx_q.push_back(CH_START);
        tx_q.push_back(CH_NUL);
        tx_q.push_back(CH_END);
        send_queued();
    endtask

    task automatic test_frame_length();
        sender_bursty = 1'b1;
        ready_mode = RDY_RANDOM;
        put_long_frame(FRAME_MAX - 1, CH_END);
        put_long_frame(FRAME_MAX, CH_END);
        put_long_frame(FRAME_MAX, 8'hA5);
        put_text("IR1:5#");  // after the abort: ignored
        put_long_frame(FRAME_MAX, CH_START);
        put_text("A,IR2:-9#");
        send_queued();
    endtask

    task automatic test_random_stream();
        int target;
        target = frame_bytes + RANDOM_BYTES;
        while (frame_bytes < target) begin
            if ($urandom_range(0, 7) == 0) begin
                sender_bursty = ($urandom_range(0, 2) != 0);
                ready_mode = ready_mode_t'($urandom_range(0, 2));
            end
            put_random_frame();
            send_queued();
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_ignored_bytes();
        test_basic_frames();
        test_value_extremes();
        test_value_forms();
        test_token_rules();
        test_headers();
        test_zero_byte();
        test_frame_length();
        test_random_stream();
        s_valid <= 1'b0;
        while (frame_reports_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Fed %0d frame bytes; checked %0d reports (%0d ok, %0d bad header, %0d too long).",
                 frame_bytes, reports_checked, reports_ok, reports_bad_header, reports_too_long);
        $display("Sender bursts and receiver stalls were mixed in; %0d field mismatches logged.",
                 mismatch_count);
        if (mismatch_count == 0 && frame_reports_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
